FILE: rtl/tfd_pkg.sv
// shared types, codes and color expansion functions for the texel format decoder
package tfd_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;

	localparam logic [31:0] MAGENTA = 32'hFFFF00FF;

	typedef logic [2:0] fmt_t;
	typedef logic [1:0] size_t;
	typedef logic       cfg_index_t;

	localparam fmt_t FMT_RGBA = 3'd0;
	localparam fmt_t FMT_YUV  = 3'd1;
	localparam fmt_t FMT_CI   = 3'd2;
	localparam fmt_t FMT_IA   = 3'd3;
	localparam fmt_t FMT_I    = 3'd4;

	localparam size_t SZ_4  = 2'd0;
	localparam size_t SZ_8  = 2'd1;
	localparam size_t SZ_16 = 2'd2;
	localparam size_t SZ_32 = 2'd3;

	localparam logic OP_DECODE  = 1'b0;
	localparam logic OP_PALETTE = 1'b1;

	localparam cfg_index_t CFG_FORMAT = 1'b0;
	localparam cfg_index_t CFG_SIZE   = 1'b1;

	localparam fmt_t  FORMAT_RESET = FMT_RGBA;
	localparam size_t SIZE_RESET   = SZ_16;

	// element beat after the palette read
	typedef struct packed {
		logic [31:0] element;
		logic [15:0] pal_hi;
		logic [15:0] pal_lo;
		logic        hi_ok;
		logic        image_end;
	} tfd_s2_t;

	// decoded pixels of one element
	typedef struct packed {
		logic [31:0] px0;
		logic [31:0] px1;
		logic        two;
		logic        image_end;
	} tfd_pair_t;

	function automatic logic [31:0] grey(input logic [7:0] a, input logic [7:0] i);
		return {a, i, i, i};
	endfunction

	function automatic logic [31:0] from5551(input logic [15:0] p);
		logic [7:0] a;
		a = p[0] ? 8'hFF : 8'h00;
		return {a, p[5:1], 3'b000, p[10:6], 3'b000, p[15:11], 3'b000};
	endfunction

	function automatic logic [31:0] decode_nibble(input fmt_t fmt, input logic [3:0] v,
			input logic [31:0] pal);
		logic [2:0]  i3;
		logic [7:0]  a;
		logic [31:0] px;
		i3 = v[3:1];
		a  = v[0] ? 8'hFF : 8'h00;
		unique case (fmt)
			FMT_CI:  px = pal;
			FMT_IA:  px = grey(a, {i3, i3, i3[2:1]});
			FMT_I:   px = grey(8'hFF, {v, v});
			default: px = MAGENTA;
		endcase
		return px;
	endfunction

	function automatic logic [31:0] decode_single(input fmt_t fmt, input size_t sz,
			input logic [31:0] e, input logic [31:0] pal);
		logic [31:0] px;
		priority if (fmt == FMT_RGBA && sz == SZ_16)
			px = from5551(e[15:0]);
		else if (fmt == FMT_RGBA && sz == SZ_32)
			px = {e[7:0], e[15:8], e[23:16], e[31:24]};
		else if (fmt == FMT_IA && sz == SZ_8)
			px = grey({e[3:0], e[3:0]}, {e[7:4], e[7:4]});
		else if (fmt == FMT_IA && sz == SZ_16)
			px = grey(e[7:0], e[15:8]);
		else if (fmt == FMT_I && sz == SZ_8)
			px = grey(8'hFF, e[7:0]);
		else if (fmt == FMT_CI && sz == SZ_8)
			px = pal;
		else
			px = MAGENTA;
		return px;
	endfunction

endpackage

FILE: rtl/tfd_front.sv
// input stage and palette memory with one write and two registered read ports
module tfd_front #(
	parameter int PALETTE_DEPTH = tfd_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [31:0]          raw_element,
	input  logic [7:0]           palette_index,
	input  logic [15:0]          palette_entry,
	input  logic                 image_end,
	input  tfd_pkg::size_t       texel_size,
	output logic                 s2_valid,
	input  logic                 s2_ready,
	output tfd_pkg::tfd_s2_t     s2_beat
);
	import tfd_pkg::*;

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);
	localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

	logic              v_s1;
	logic              op_s1;
	logic [31:0]       elem_s1;
	logic [7:0]        pidx_s1;
	logic [15:0]       pent_s1;
	logic              end_s1;

	logic              v_s2;
	logic [31:0]       elem_s2;
	logic [15:0]       pal_hi_s2;
	logic [15:0]       pal_lo_s2;
	logic              hi_ok_s2;
	logic              end_s2;

	logic              s1_go;
	logic              rd_en;
	logic              wr_en;
	logic              nib_mode;
	logic [PAL_AW-1:0] addr_hi;
	logic [PAL_AW-1:0] addr_lo;
	logic              hi_ok;

	logic [15:0] pal_mem [PALETTE_DEPTH];

	function automatic logic [PAL_AW-1:0] pidx_rd(input logic [7:0] idx);
		return idx[PAL_AW-1:0];
	endfunction

	// palette writes leave stage one without a downstream slot
	assign s1_go    = v_s1 && (op_s1 == OP_PALETTE || !v_s2 || s2_ready);
	assign in_ready = !v_s1 || s1_go;
	assign rd_en    = s1_go && op_s1 == OP_DECODE;
	assign wr_en    = s1_go && op_s1 == OP_PALETTE && ({1'b0, pidx_s1} < DEPTH_W);
	assign nib_mode = texel_size == SZ_4;
	assign addr_hi  = nib_mode ? PAL_AW'(elem_s1[7:4]) : pidx_rd(elem_s1[7:0]);
	assign addr_lo  = PAL_AW'(elem_s1[3:0]);
	assign hi_ok    = nib_mode || ({1'b0, elem_s1[7:0]} < DEPTH_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (rd_en)
				v_s2 <= 1'b1;
			else if (s2_ready)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			elem_s1 <= raw_element;
			pidx_s1 <= palette_index;
			pent_s1 <= palette_entry;
			end_s1  <= image_end;
		end
		if (rd_en) begin
			elem_s2  <= elem_s1;
			hi_ok_s2 <= hi_ok;
			end_s2   <= end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			pal_mem[pidx_s1[PAL_AW-1:0]] <= pent_s1;
		if (rd_en) begin
			pal_hi_s2 <= pal_mem[addr_hi];
			pal_lo_s2 <= pal_mem[addr_lo];
		end
	end

	assign s2_valid          = v_s2;
	assign s2_beat.element   = elem_s2;
	assign s2_beat.pal_hi    = pal_hi_s2;
	assign s2_beat.pal_lo    = pal_lo_s2;
	assign s2_beat.hi_ok     = hi_ok_s2;
	assign s2_beat.image_end = end_s2;

	a_write_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && op_s1 == OP_PALETTE |-> in_ready)
		else $error("palette write held in stage one");

	a_read_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> v_s2)
		else $error("palette read lost its beat");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !s2_ready |=> v_s2 && $stable(elem_s2))
		else $error("stage two changed under stall");

endmodule

FILE: rtl/tfd_decode.sv
// color expansion stage: turns an element and its palette colors into one or two pixels
module tfd_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  tfd_pkg::fmt_t      texel_format,
	input  tfd_pkg::size_t     texel_size,
	input  logic               s2_valid,
	output logic               s2_ready,
	input  tfd_pkg::tfd_s2_t   s2_beat,
	output logic               s3_valid,
	input  logic               s3_ready,
	output tfd_pkg::tfd_pair_t s3_pair
);
	import tfd_pkg::*;

	logic      v_s3;
	tfd_pair_t pair_s3;
	tfd_pair_t pair_d;
	logic [31:0] col_hi;
	logic [31:0] col_lo;

	// out of range index reads as color zero
	assign col_hi = from5551(s2_beat.hi_ok ? s2_beat.pal_hi : 16'h0000);
	assign col_lo = from5551(s2_beat.pal_lo);

	always_comb begin
		pair_d.image_end = s2_beat.image_end;
		if (texel_size == SZ_4) begin
			pair_d.px0 = decode_nibble(texel_format, s2_beat.element[7:4], col_hi);
			pair_d.px1 = decode_nibble(texel_format, s2_beat.element[3:0], col_lo);
			pair_d.two = 1'b1;
		end else begin
			pair_d.px0 = decode_single(texel_format, texel_size, s2_beat.element, col_hi);
			pair_d.px1 = MAGENTA;
			pair_d.two = 1'b0;
		end
	end

	assign s2_ready = !v_s3 || s3_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (s2_ready)
			v_s3 <= s2_valid;
	end

	always_ff @(posedge clk) begin
		if (s2_valid && s2_ready)
			pair_s3 <= pair_d;
	end

	assign s3_valid = v_s3;
	assign s3_pair  = pair_s3;

endmodule

FILE: rtl/tfd_serial.sv
// output register that sends the one or two pixels of an element as separate beats
module tfd_serial (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pair_valid,
	output logic               pair_ready,
	input  tfd_pkg::tfd_pair_t pair,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        pixel_abgr,
	output logic               run_last,
	output logic               image_last
);
	import tfd_pkg::*;

	logic      valid_q;
	logic      phase_q;
	tfd_pair_t pair_q;
	logic      last_beat;

	assign run_last   = !pair_q.two || phase_q;
	assign image_last = run_last && pair_q.image_end;
	assign pixel_abgr = phase_q ? pair_q.px1 : pair_q.px0;
	assign out_valid  = valid_q;
	assign last_beat  = valid_q && out_ready && run_last;
	assign pair_ready = !valid_q || last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (pair_valid && pair_ready) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (valid_q && out_ready) begin
			if (run_last) begin
				valid_q <= 1'b0;
				phase_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pair_valid && pair_ready)
			pair_q <= pair;
	end

	a_phase_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_q && pair_q.two)
		else $error("second pixel without a two pixel element");

	a_first_then_second: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_ready && !run_last |=> valid_q && phase_q)
		else $error("second pixel dropped");

	a_load_first: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_ready |=> valid_q && !phase_q)
		else $error("new element did not start at its first pixel");

endmodule

FILE: rtl/texel_format_decoder_unit.sv
// top level of the texel format decoder: config registers and the pixel pipeline
// Takes one beat per cycle on the input while in_ready is high: a texel element
// to decode or a palette entry to store. An element goes through the input
// register and palette read, the color expansion register and the output
// register before its first pixel is offered. The output sends one pixel per
// cycle while out_ready is high: 4-bit elements give two pixels as separate
// beats and take no new element until the second is sent, every other size
// runs at one element per cycle. A palette write takes one input beat, gives
// no pixel and is seen by every element behind it. Write texel_format and
// texel_size only while no element is in flight.
module texel_format_decoder_unit #(
	parameter int PALETTE_DEPTH = tfd_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  tfd_pkg::cfg_index_t  cfg_index,
	input  logic [2:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [31:0]          raw_element,
	input  logic [7:0]           palette_index,
	input  logic [15:0]          palette_entry,
	input  logic                 image_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          pixel_abgr,
	output logic                 run_last,
	output logic                 image_last
);
	import tfd_pkg::*;

	fmt_t      texel_format_q;
	size_t     texel_size_q;
	logic      s2_valid;
	logic      s2_ready;
	tfd_s2_t   s2_beat;
	logic      s3_valid;
	logic      s3_ready;
	tfd_pair_t s3_pair;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texel_format_q <= FORMAT_RESET;
			texel_size_q   <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FORMAT: texel_format_q <= cfg_data;
				CFG_SIZE:   texel_size_q   <= cfg_data[1:0];
			endcase
		end
	end

	tfd_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.raw_element  (raw_element),
		.palette_index(palette_index),
		.palette_entry(palette_entry),
		.image_end    (image_end),
		.texel_size   (texel_size_q),
		.s2_valid     (s2_valid),
		.s2_ready     (s2_ready),
		.s2_beat      (s2_beat)
	);

	tfd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.texel_format(texel_format_q),
		.texel_size  (texel_size_q),
		.s2_valid    (s2_valid),
		.s2_ready    (s2_ready),
		.s2_beat     (s2_beat),
		.s3_valid    (s3_valid),
		.s3_ready    (s3_ready),
		.s3_pair     (s3_pair)
	);

	tfd_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair_valid(s3_valid),
		.pair_ready(s3_ready),
		.pair      (s3_pair),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_abgr(pixel_abgr),
		.run_last  (run_last),
		.image_last(image_last)
	);

endmodule
